/* src/merge_sort_search_engine_defines.svh */
// Assertion helpers for the merge sort / search engine.
`ifndef MERGE_SORT_SEARCH_ENGINE_DEFINES_SVH
`define MERGE_SORT_SEARCH_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MSSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MSSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mss_pkg.sv */
package mss_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] KIND_SORT   = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam int VAL_W = 32;

    // Compare unit request/response.
    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic le;
        logic eq;
        logic lt;
    } t_cmp_rsp;

endpackage

/* src/mss_cmp.sv */
// Shared signed comparator used by merge and search steps.
module mss_cmp (
    input  mss_pkg::t_cmp_req i_req,
    output mss_pkg::t_cmp_rsp o_rsp
);
    assign o_rsp.lt = i_req.a < i_req.b;
    assign o_rsp.eq = i_req.a == i_req.b;
    assign o_rsp.le = i_req.a <= i_req.b;
endmodule

/* src/merge_sort_search_engine.sv */
// Merge sort and binary search engine. An item is taken when start is high and busy is low;
// busy stays high until the item is done, and any result shows for exactly one cycle on
// o_valid. The receiver cannot stall: it must take the result in the cycle it is shown.
// A load without last (cmd 0) is taken and leaves busy low, so loads can follow back to
// back. A load with last starts a bottom-up merge sort. Each pass merges entry by entry
// (read a, read b, compare and write scratch) and then copies each entry back (read
// scratch, wait, write store), with a setup step (S_RUN) for each run pair and for each
// pass. When the run width reaches the item count, the result is shown. A search makes up
// to floor(log2 n)+1 probes, each a probe read and a compare. A miss ends with one more
// probe read that finds the bounds crossed, then the result is shown. A read captures the
// store data in S_RRD and shows its result in S_OUT. The unused command code is taken,
// leaves busy low and gives no result.
module merge_sort_search_engine #(
    parameter int MAX_ITEMS = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_cmd,
    input  logic signed [31:0]  i_value,
    input  logic [8:0]          i_index,
    input  logic                i_last,
    output logic                o_valid,
    output logic [1:0]          o_kind,
    output logic                o_found,
    output logic [8:0]          o_position,
    output logic signed [31:0]  o_data,
    output logic [9:0]          o_item_total,
    output logic                o_error
);
`include "merge_sort_search_engine_defines.svh"

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = CW + 1;   // room for lo + 2*width overshoot
    localparam int SW = XW + 1;   // signed search bounds

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RUN   = 4'd1;  // set up a run pair
    localparam logic [3:0] S_RDA   = 4'd2;  // issue store read at a
    localparam logic [3:0] S_RDB   = 4'd3;  // capture a, read b
    localparam logic [3:0] S_MRG   = 4'd4;  // capture b, compare, write scratch
    localparam logic [3:0] S_CPR   = 4'd5;  // copy-back read
    localparam logic [3:0] S_CPW   = 4'd6;  // copy-back write
    localparam logic [3:0] S_SRD   = 4'd7;  // search probe read
    localparam logic [3:0] S_SCMP  = 4'd8;  // search compare
    localparam logic [3:0] S_RRD   = 4'd9;  // read-cmd data wait
    localparam logic [3:0] S_OUT   = 4'd10; // result strobe
    localparam logic [3:0] S_SWAIT = 4'd11; // scratch read latency

    logic [3:0] r_state, n_state;

    logic signed [31:0] r_store   [MAX_ITEMS];
    logic signed [31:0] r_scratch [MAX_ITEMS];
    logic signed [31:0] r_st_q, r_sc_q;
    logic [AW-1:0]      st_raddr, sc_raddr, st_waddr, sc_waddr;
    logic               st_we, sc_we;
    logic signed [31:0] st_wdata, sc_wdata;

    logic [CW-1:0] r_count;
    logic          r_ovf, r_done;
    logic [XW-1:0] r_width, r_lo, r_mid, r_hi, r_a, r_b, r_k;
    logic signed [31:0] r_va, r_key;
    logic signed [XW:0] r_slo, r_shi, smid;
    logic [1:0]    r_kind;
    logic          r_found, r_err;
    logic [8:0]    r_pos;
    logic signed [31:0] r_data;
    logic [8:0]    r_idx;

    mss_pkg::t_cmp_req cmp_req;
    mss_pkg::t_cmp_rsp cmp_rsp;

    mss_cmp u_cmp (.i_req(cmp_req), .o_rsp(cmp_rsp));

    always_ff @(posedge i_clk) begin
        if (st_we) r_store[st_waddr] <= st_wdata;
        r_st_q <= r_store[st_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (sc_we) r_scratch[sc_waddr] <= sc_wdata;
        r_sc_q <= r_scratch[sc_raddr];
    end

    assign busy = (r_state != S_IDLE);
    wire accept = start && !busy;
    wire [CW-1:0] cnt_eff = r_done ? '0 : r_count;
    assign smid = r_slo + ((r_shi - r_slo) >>> 1);

    // Shared comparator operands by state.
    always_comb begin
        cmp_req.a = r_va;
        cmp_req.b = r_st_q;
        if (r_state == S_SCMP) begin
            cmp_req.a = r_st_q;
            cmp_req.b = r_key;
        end
    end

    wire a_ok = r_a < r_mid;
    wire b_ok = r_b < r_hi;

    always_comb begin
        st_raddr = r_a[AW-1:0];
        sc_raddr = r_k[AW-1:0];
        unique case (r_state)
            S_RDB:  st_raddr = r_b[AW-1:0];
            S_MRG:  st_raddr = r_b[AW-1:0];
            S_SRD:  st_raddr = smid[AW-1:0];
            S_RRD:  st_raddr = r_idx[AW-1:0];
            S_IDLE: st_raddr = i_index[AW-1:0];
            default: st_raddr = r_a[AW-1:0];
        endcase
    end

    always_comb begin
        st_we = 1'b0; st_waddr = cnt_eff[AW-1:0]; st_wdata = i_value;
        sc_we = 1'b0; sc_waddr = r_k[AW-1:0];
        sc_wdata = r_va;
        if (accept && i_cmd == mss_pkg::CMD_LOAD && cnt_eff < CW'(MAX_ITEMS))
            st_we = 1'b1;
        if (r_state == S_MRG) begin
            sc_we = 1'b1;
            if (a_ok && (!b_ok || cmp_rsp.le)) sc_wdata = r_va;
            else sc_wdata = r_st_q;
        end
        if (r_state == S_CPW) begin
            st_we = 1'b1; st_waddr = r_k[AW-1:0]; st_wdata = r_sc_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key <= i_value;
                        r_idx <= i_index;
                        r_found <= 1'b0; r_pos <= '0; r_data <= '0; r_err <= 1'b0;
                        r_slo <= '0;
                        r_shi <= SW'($signed({1'b0, XW'(r_count)}) - 1);
                        unique case (i_cmd)
                            mss_pkg::CMD_LOAD: begin
                                if (r_done) begin
                                    r_done <= 1'b0; r_ovf <= 1'b0;
                                end
                                if (cnt_eff < CW'(MAX_ITEMS)) r_count <= cnt_eff + 1'b1;
                                else begin
                                    r_count <= cnt_eff;
                                    r_ovf <= 1'b1;
                                end
                                r_kind <= mss_pkg::KIND_SORT;
                                r_width <= XW'(1);
                                r_lo <= '0;
                            end
                            mss_pkg::CMD_SEARCH: r_kind <= mss_pkg::KIND_SEARCH;
                            mss_pkg::CMD_READ: begin
                                r_kind <= mss_pkg::KIND_READ;
                                r_err <= ({1'b0, i_index} >= XW'(r_count));
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN: begin
                    if (r_lo < XW'(r_count)) begin
                        r_a <= r_lo; r_k <= r_lo;
                        r_mid <= (r_lo + r_width < XW'(r_count)) ? r_lo + r_width
                                                                : XW'(r_count);
                        r_b <= (r_lo + r_width < XW'(r_count)) ? r_lo + r_width
                                                              : XW'(r_count);
                        r_hi <= (r_lo + (r_width << 1) < XW'(r_count))
                                ? r_lo + (r_width << 1) : XW'(r_count);
                    end else begin
                        r_k <= '0;
                    end
                end
                S_RDA: ;
                S_RDB: r_va <= r_st_q;
                S_MRG: begin
                    r_k <= r_k + 1'b1;
                    if (a_ok && (!b_ok || cmp_rsp.le)) r_a <= r_a + 1'b1;
                    else r_b <= r_b + 1'b1;
                    if (r_k + 1'b1 == r_hi) r_lo <= r_lo + (r_width << 1);
                end
                S_CPR: ;
                S_SWAIT: ;
                S_CPW: begin
                    r_k <= r_k + 1'b1;
                    if (r_k + 1'b1 == XW'(r_count)) begin
                        r_width <= r_width << 1;
                        r_lo <= '0;
                    end
                end
                S_SRD: ;
                S_SCMP: begin
                    if (cmp_rsp.eq) begin
                        r_found <= 1'b1;
                        r_pos <= 9'(smid);
                    end else if (cmp_rsp.lt) r_slo <= SW'(smid + 1);
                    else r_shi <= SW'(smid - 1);
                end
                S_RRD: if (!r_err) r_data <= r_st_q;
                S_OUT: if (r_kind == mss_pkg::KIND_SORT) r_done <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) begin
                unique case (i_cmd)
                    mss_pkg::CMD_LOAD:   n_state = i_last ? S_RUN : S_IDLE;
                    mss_pkg::CMD_SEARCH: n_state = S_SRD;
                    mss_pkg::CMD_READ:   n_state = S_RRD;
                    default:             n_state = S_IDLE;
                endcase
            end
            S_RUN: begin
                if (r_width >= XW'(r_count)) n_state = S_OUT;
                else if (r_lo < XW'(r_count)) n_state = S_RDA;
                else n_state = S_CPR;
            end
            S_RDA: n_state = S_RDB;
            S_RDB: n_state = S_MRG;
            // after a write, reload the operand that moved
            S_MRG: n_state = (r_k + 1'b1 == r_hi) ? S_RUN : S_RDA;
            S_CPR: n_state = S_SWAIT;
            S_SWAIT: n_state = S_CPW;
            S_CPW: n_state = (r_k + 1'b1 == XW'(r_count)) ? S_RUN : S_CPR;
            S_SRD: n_state = (r_slo > r_shi) ? S_OUT : S_SCMP;
            S_SCMP: n_state = cmp_rsp.eq ? S_OUT : S_SRD;
            S_RRD: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid      = (r_state == S_OUT);
    assign o_kind       = r_kind;
    assign o_found      = r_found;
    assign o_position   = r_pos;
    assign o_data       = r_data;
    assign o_item_total = 10'(r_count);
    assign o_error      = (r_kind == mss_pkg::KIND_SORT) ? r_ovf
                        : (r_kind == mss_pkg::KIND_READ) ? r_err : 1'b0;

    `MSSE_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ITEMS), "count over cap")
    `MSSE_ASSERT_NXT(a_out_one, i_clk, i_rst_n, o_valid, !o_valid, "strobe held")
    `MSSE_ASSERT_IMP(a_found_kind, i_clk, i_rst_n, o_valid && o_found,
                     o_kind == mss_pkg::KIND_SEARCH, "found on wrong kind")
endmodule

/* dv/merge_sort_search_engine_tb.sv */
module merge_sort_search_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Code the block has no use for; it must be dropped silently.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STORE_DEPTH = 512;
    // Cycles allowed with neither an accept nor an answer; must cover a full 512-entry sort.
    localparam int STALL_LIMIT = 200000;
    // Quiet cycles after the last answer, to catch stray strobes.
    localparam int TAIL_CYCLES = 100;
    // The final stretch of items runs without idling.
    localparam int NO_IDLE_TAIL = 150;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] value;
        logic [8:0]         index;
        logic               last;
        bit                 drain;  // hold off until every result is back
    } t_cmd_item;

    typedef struct {
        logic [1:0]         kind;
        logic               found;
        logic [8:0]         position;
        logic signed [31:0] data;
        logic [9:0]         item_total;
        logic               error;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_cmd = mss_pkg::CMD_LOAD;
    logic signed [31:0] i_value = '0;
    logic [8:0]         i_index = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic               o_found;
    logic [8:0]         o_position;
    logic signed [31:0] o_data;
    logic [9:0]         o_item_total;
    logic               o_error;

    merge_sort_search_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_found      (o_found),
        .o_position   (o_position),
        .o_data       (o_data),
        .o_item_total (o_item_total),
        .o_error      (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the engine state
    // ---------------------------------------------------------------
    logic signed [31:0] shadow_store [STORE_DEPTH];
    logic signed [31:0] shadow_scratch [STORE_DEPTH];
    int unsigned        shadow_count;
    bit                 shadow_overflow;
    bit                 shadow_sorted;

    t_cmd_item pending_items[$];
    t_answer   expected_answers[$];
    int        mismatch_count;
    int        stall_cycles;

    // Bottom-up merge, ties take the left run so equal values keep order.
    task automatic sort_shadow();
        int n;
        int w;
        int lo;
        int mid;
        int hi;
        int a;
        int b;
        int k;
        n = shadow_count;
        for (w = 1; w < n; w = w * 2) begin
            for (lo = 0; lo < n; lo = lo + 2 * w) begin
                mid = (lo + w < n) ? lo + w : n;
                hi  = (lo + 2 * w < n) ? lo + 2 * w : n;
                a = lo;
                b = mid;
                k = lo;
                while (a < mid && b < hi) begin
                    if (shadow_store[a] <= shadow_store[b]) begin
                        shadow_scratch[k] = shadow_store[a];
                        a++;
                    end else begin
                        shadow_scratch[k] = shadow_store[b];
                        b++;
                    end
                    k++;
                end
                while (a < mid) begin
                    shadow_scratch[k] = shadow_store[a];
                    a++;
                    k++;
                end
                while (b < hi) begin
                    shadow_scratch[k] = shadow_store[b];
                    b++;
                    k++;
                end
            end
            for (k = 0; k < n; k++) shadow_store[k] = shadow_scratch[k];
        end
    endtask

    // Apply one accepted item to the shadow state and queue its answer.
    task automatic apply_item(input t_cmd_item it);
        t_answer ans;
        int lo;
        int hi;
        int mid;
        ans = '{kind: mss_pkg::KIND_SORT, found: 1'b0, position: '0, data: '0,
                item_total: '0, error: 1'b0};
        case (it.cmd)
            mss_pkg::CMD_LOAD: begin
                if (shadow_sorted) begin
                    shadow_count = 0;
                    shadow_overflow = 0;
                    shadow_sorted = 0;
                end
                if (shadow_count < STORE_DEPTH) begin
                    shadow_store[shadow_count] = it.value;
                    shadow_count++;
                end else begin
                    shadow_overflow = 1;
                end
                if (it.last) begin
                    sort_shadow();
                    shadow_sorted = 1;
                    ans.kind = mss_pkg::KIND_SORT;
                    ans.item_total = shadow_count[9:0];
                    ans.error = shadow_overflow;
                    expected_answers.push_back(ans);
                end
            end
            mss_pkg::CMD_SEARCH: begin
                lo = 0;
                hi = int'(shadow_count) - 1;
                ans.kind = mss_pkg::KIND_SEARCH;
                ans.item_total = shadow_count[9:0];
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_store[mid] == it.value) begin
                        ans.found = 1'b1;
                        ans.position = mid[8:0];
                        break;
                    end
                    if (shadow_store[mid] < it.value) lo = mid + 1;
                    else hi = mid - 1;
                end
                expected_answers.push_back(ans);
            end
            mss_pkg::CMD_READ: begin
                ans.kind = mss_pkg::KIND_READ;
                ans.item_total = shadow_count[9:0];
                if (it.index < shadow_count) ans.data = shadow_store[it.index];
                else ans.error = 1'b1;
                expected_answers.push_back(ans);
            end
            default: ;  // unused code: no answer, no state change
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        mismatch_count++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Driver: keeps start high while an item waits, idles in bursts
    // ---------------------------------------------------------------
    int idle_left;

    always @(posedge i_clk) begin
        t_cmd_item nxt;
        bit        have_item;
        bit        taken;
        have_item = 0;
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                apply_item(pending_items.pop_front());
                stall_cycles = 0;
            end
            if (!start || taken) begin
                // head marker: wait here until every answer is back
                if (pending_items.size() > 0 && pending_items[0].drain) begin
                    if (expected_answers.size() == 0) void'(pending_items.pop_front());
                end else if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_items.size() > NO_IDLE_TAIL &&
                             $urandom_range(0, 5) == 0) begin
                    idle_left = $urandom_range(1, 9) - 1;
                end else if (pending_items.size() > 0 && !pending_items[0].drain) begin
                    nxt = pending_items[0];
                    have_item = 1;
                end
                start <= have_item;
                if (have_item) begin
                    i_cmd   <= nxt.cmd;
                    i_value <= nxt.value;
                    i_index <= nxt.index;
                    i_last  <= nxt.last;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every strobed answer is matched against the oldest one
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            stall_cycles = 0;
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected answer, kind", o_kind, -1);
            end else begin
                want = expected_answers.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", o_kind, want.kind);
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_position !== want.position)
                    report_mismatch("position", o_position, want.position);
                if (o_data !== want.data) report_mismatch("data", o_data, want.data);
                if (o_item_total !== want.item_total)
                    report_mismatch("item_total", o_item_total, want.item_total);
                if (o_error !== want.error) report_mismatch("error", o_error, want.error);
            end
        end
    end

    // Watchdog on cycles with neither an item nor an answer accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int added;
    logic signed [31:0] set_values[$];

    task automatic add(input logic [1:0] cmd, input logic signed [31:0] value,
                       input logic [8:0] index, input logic last);
        pending_items.push_back('{cmd: cmd, value: value, index: index,
                                  last: last, drain: 0});
        added++;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 15)) - 8;   // dense duplicates
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    // One load set with random content, then searches and reads over it.
    task automatic add_set(input int size, input int queries);
        logic signed [31:0] v;
        int j;
        set_values.delete();
        for (j = 0; j < size; j++) begin
            v = rand_value();
            set_values.push_back(v);
            add(mss_pkg::CMD_LOAD, v, 9'($urandom), j == size - 1);
            // noise: unused code or early query in the middle of a set
            if ($urandom_range(0, 30) == 0)
                add(CMD_UNUSED, $urandom, 9'($urandom), 1'($urandom));
            if ($urandom_range(0, 40) == 0)
                add(mss_pkg::CMD_READ, $urandom, 9'($urandom_range(0, j)), 1'b0);
        end
        for (j = 0; j < queries; j++) begin
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 2) != 0)
                    v = set_values[$urandom_range(0, set_values.size() - 1)];
                else
                    v = rand_value();
                add(mss_pkg::CMD_SEARCH, v, 9'($urandom), 1'($urandom));
            end else if ($urandom_range(0, 3) != 0) begin
                add(mss_pkg::CMD_READ, $urandom,
                    9'($urandom_range(0, size < 512 ? size : 511)), 1'($urandom));
            end else begin
                add(mss_pkg::CMD_READ, $urandom, 9'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        stall_cycles = 0;
        added = 0;
        shadow_count = 0;
        shadow_overflow = 0;
        shadow_sorted = 0;

        // directed: empty store, extremes, duplicates, unsorted queries
        add(mss_pkg::CMD_SEARCH, 32'sd0, 9'd0, 1'b0);
        add(mss_pkg::CMD_READ, 32'sd0, 9'd0, 1'b0);
        add(CMD_UNUSED, 32'sh7FFF_FFFF, 9'd511, 1'b1);
        add(mss_pkg::CMD_LOAD, 32'sh7FFF_FFFF, 9'd511, 1'b0);
        add(mss_pkg::CMD_LOAD, 32'sh8000_0000, 9'd0, 1'b0);
        add(mss_pkg::CMD_LOAD, 32'sd5, 9'd0, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sd5, 9'd0, 1'b0);          // search before sort
        add(mss_pkg::CMD_READ, 32'sd0, 9'd1, 1'b0);            // read before sort
        add(mss_pkg::CMD_LOAD, -32'sd1, 9'd0, 1'b0);
        add(mss_pkg::CMD_LOAD, 32'sd5, 9'd0, 1'b0);
        add(mss_pkg::CMD_LOAD, 32'sd0, 9'd0, 1'b1);
        add(mss_pkg::CMD_READ, 32'sd0, 9'd0, 1'b0);
        add(mss_pkg::CMD_READ, 32'sd0, 9'd5, 1'b0);
        add(mss_pkg::CMD_READ, 32'sd0, 9'd6, 1'b0);            // just out of range
        add(mss_pkg::CMD_READ, 32'sd0, 9'd511, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sh8000_0000, 9'd0, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sh7FFF_FFFF, 9'd0, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sd5, 9'd0, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sd3, 9'd0, 1'b0);          // miss
        add(mss_pkg::CMD_LOAD, 32'sd42, 9'd0, 1'b1);           // new set of one
        add(mss_pkg::CMD_SEARCH, 32'sd42, 9'd0, 1'b0);
        add(mss_pkg::CMD_SEARCH, 32'sd41, 9'd0, 1'b0);

        // random sets; one overflows the store with last on the dropped load
        add_set($urandom_range(2, 30), 20);
        add_set(520, 40);
        pending_items.push_back('{cmd: mss_pkg::CMD_LOAD, value: 0, index: 0, last: 0,
                                  drain: 1});
        while (added < 1650) begin
            if ($urandom_range(0, 15) == 0) add_set(1, 6);
            else add_set($urandom_range(2, 40), $urandom_range(5, 30));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_items.size() != 0 || start || expected_answers.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
